FILE: rtl/core/hrr_pkg.sv
// Shared constants, types and helpers for the hue range remapper.
package hrr_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FIELD_BITS     = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int ADDR_BITS      = 5;
    localparam int DATA_BITS      = 32;

    localparam logic [1:0] KIND_PASS   = 2'd0;
    localparam logic [1:0] KIND_DIRECT = 2'd1;
    localparam logic [1:0] KIND_MAP    = 2'd2;

    localparam logic [1:0] GM_FROM = 2'd1;
    localparam logic [1:0] GM_TO   = 2'd2;

    localparam logic [2:0] REG_SRC_START = 3'd0;
    localparam logic [2:0] REG_SRC_END   = 3'd1;
    localparam logic [2:0] REG_TGT_START = 3'd2;
    localparam logic [2:0] REG_TGT_END   = 3'd3;
    localparam logic [2:0] REG_MODE      = 3'd4;
    localparam logic [2:0] REG_GRAY_LIM  = 3'd5;
    localparam logic [2:0] REG_GRAY_HUE  = 3'd6;
    localparam logic [2:0] REG_GRAY_SAT  = 3'd7;

    typedef struct packed {
        logic [15:0] source_start;
        logic [15:0] source_end;
        logic [15:0] target_start;
        logic [15:0] target_end;
        logic [3:0]  mode_bits;
        logic [15:0] gray_limit;
        logic [15:0] gray_target_hue;
        logic [15:0] gray_target_sat;
    } cfg_t;

    // kind, hue, sat, neg, then four angle-sized fields of width w+1
    function automatic int item_bits(input int w);
        return 35 + 4 * (w + 1);
    endfunction

endpackage

FILE: rtl/core/hrr_queue.sv
// Short item queue between the classifier and the arithmetic pipeline.
module hrr_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = hrr_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wr_data,
    input  logic          pop,
    output logic [DW-1:0] rd_data,
    output logic          full,
    output logic          empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [0:DEPTH-1];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/hrr_front.sv
// Input stage: slice geometry, gray handling and item classification.
module hrr_front #(
    parameter int W = hrr_pkg::ANGLE_BITS_DEF,
    parameter int IW = hrr_pkg::item_bits(W)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  hrr_pkg::cfg_t    cfg,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [15:0]      hue_in,
    input  logic [15:0]      sat_in,
    input  logic             q_full,
    output logic             q_push,
    output logic [IW-1:0]    q_data
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] hue;
        logic [15:0] sat;
        logic        neg;
        logic [W:0]  dcm;
        logic [W:0]  tam;
        logic [W:0]  ud;
        logic [W:0]  c;
    } item_t;

    function automatic logic [W-1:0] ang(input logic [15:0] v);
        logic [W+15:0] e;
        e = {{W{1'b0}}, v};
        return e[W-1:0];
    endfunction

    function automatic logic [15:0] to16(input logic [W-1:0] v);
        logic [W+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    logic  [W-1:0] ss, se, ts, te, g, x, dsrc, nsrc;
    logic          sneg, tneg, gray, gfrom, gto, g_in_src;
    logic  [1:0]   gm;
    logic  [W:0]   a, b, c, d, lo, hi, xx, xt, t;
    logic          in1, in2, zw, hit0;
    item_t         item_next, item_reg;
    logic          valid_reg, accept;

    always_comb
    begin
        ss    = ang(cfg.source_start);
        se    = ang(cfg.source_end);
        ts    = ang(cfg.target_start);
        te    = ang(cfg.target_end);
        g     = ang(cfg.gray_target_hue);
        sneg  = cfg.mode_bits[0];
        tneg  = cfg.mode_bits[1];
        gm    = cfg.mode_bits[3:2];
        gray  = (sat_in <= cfg.gray_limit);
        gfrom = gray && (gm == hrr_pkg::GM_FROM);
        gto   = gray && (gm == hrr_pkg::GM_TO);

        dsrc     = sneg ? ss - se : se - ss;
        nsrc     = sneg ? g - se : se - g;
        g_in_src = (dsrc != '0) && (nsrc <= dsrc);

        a  = {sneg && (ss < se), ss};
        b  = {!sneg && (se < ss), se};
        c  = {tneg && (ts < te), ts};
        d  = {!tneg && (te < ts), te};
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;

        x    = gfrom ? g : ang(hue_in);
        xx   = {1'b0, x};
        xt   = {1'b1, x};
        in1  = (lo <= xx) && (xx <= hi);
        in2  = (lo <= xt) && (xt <= hi);
        t    = in1 ? xx : xt;
        zw   = (a == b);
        hit0 = (xx == a) || (xt == a);

        item_next.neg = (d < c);
        item_next.dcm = (d < c) ? c - d : d - c;
        item_next.tam = (b < a) ? a - t : t - a;
        item_next.ud  = (b < a) ? a - b : b - a;
        item_next.c   = c;
        item_next.sat = gfrom ? cfg.gray_target_sat : sat_in;

        if (gto)
        begin
            item_next.kind = hrr_pkg::KIND_DIRECT;
            item_next.hue  = cfg.gray_target_hue;
            item_next.sat  = cfg.gray_target_sat;
        end
        else if (gfrom && !g_in_src)
        begin
            item_next.kind = hrr_pkg::KIND_PASS;
            item_next.hue  = hue_in;
            item_next.sat  = sat_in;
        end
        else if (zw ? hit0 : (in1 || in2))
        begin
            item_next.kind = zw ? hrr_pkg::KIND_DIRECT : hrr_pkg::KIND_MAP;
            item_next.hue  = to16(c[W-1:0]);
        end
        else if (gfrom)
        begin
            item_next.kind = hrr_pkg::KIND_DIRECT;
            item_next.hue  = to16(g);
        end
        else
        begin
            item_next.kind = hrr_pkg::KIND_PASS;
            item_next.hue  = hue_in;
        end
    end

    assign q_push   = valid_reg && !q_full;
    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_data   = item_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: rtl/core/hrr_back.sv
// Arithmetic pipeline: multiply, rounded restoring divide, wrap and output register.
module hrr_back #(
    parameter int W = hrr_pkg::ANGLE_BITS_DEF,
    parameter int IW = hrr_pkg::item_bits(W)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  logic [IW-1:0] q_data,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [15:0]   hue_out,
    output logic [15:0]   sat_out,
    output logic          passed_through
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] hue;
        logic [15:0] sat;
        logic        neg;
        logic [W:0]  dcm;
        logic [W:0]  tam;
        logic [W:0]  ud;
        logic [W:0]  c;
    } item_t;

    localparam int PW = 2 * W + 2;
    localparam int RW = 2 * W + 3;
    localparam int NS = W + 1;

    function automatic logic [15:0] to16(input logic [W-1:0] v);
        logic [W+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    item_t         q_item;
    logic          adv;
    logic          m_valid_reg;
    item_t         m_item_reg;
    logic [PW-1:0] m_prod_reg;

    logic          st_valid_reg [0:NS];
    item_t         st_item_reg  [0:NS];
    logic [RW-1:0] st_rem_reg   [0:NS];
    logic [W:0]    st_q_reg     [0:NS];

    logic          out_valid_reg, out_pt_reg;
    logic [15:0]   out_hue_reg, out_sat_reg;
    item_t         last;
    logic [W+1:0]  h;

    assign q_item = q_data;
    assign adv    = !out_valid_reg || !out_stall;
    assign q_pop  = adv && !q_empty;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_item_reg     <= q_item;
            m_prod_reg     <= q_item.dcm * q_item.tam;
            st_item_reg[0] <= m_item_reg;
            st_rem_reg[0]  <= RW'(m_prod_reg) + RW'(m_item_reg.ud >> 1);
            st_q_reg[0]    <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg     <= 1'b0;
            st_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg     <= !q_empty;
            st_valid_reg[0] <= m_valid_reg;
        end
    end

    for (genvar j = 1; j <= NS; j++)
    begin : g_div
        localparam int SH = NS - j;
        logic [RW-1:0] den;
        logic          ge;

        assign den = RW'(st_item_reg[j-1].ud) << SH;
        assign ge  = (st_rem_reg[j-1] >= den);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                st_item_reg[j] <= st_item_reg[j-1];
                st_rem_reg[j]  <= ge ? st_rem_reg[j-1] - den : st_rem_reg[j-1];
                st_q_reg[j]    <= st_q_reg[j-1] | (ge ? ((W+1)'(1) << SH) : '0);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                st_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                st_valid_reg[j] <= st_valid_reg[j-1];
            end
        end
    end

    assign last = st_item_reg[NS];
    assign h    = last.neg ? {1'b0, last.c} - {1'b0, st_q_reg[NS]}
                           : {1'b0, last.c} + {1'b0, st_q_reg[NS]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sat_reg <= last.sat;
            case (last.kind)
                hrr_pkg::KIND_MAP:
                begin
                    out_hue_reg <= to16(h[W-1:0]);
                    out_pt_reg  <= 1'b0;
                end
                hrr_pkg::KIND_DIRECT:
                begin
                    out_hue_reg <= last.hue;
                    out_pt_reg  <= 1'b0;
                end
                default:
                begin
                    out_hue_reg <= last.hue;
                    out_pt_reg  <= 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= st_valid_reg[NS];
        end
    end

    assign out_valid      = out_valid_reg;
    assign hue_out        = out_hue_reg;
    assign sat_out        = out_sat_reg;
    assign passed_through = out_pt_reg;

endmodule

FILE: rtl/core/hue_range_remap.sv
// Top level of the hue range remapper: register port, classifier, queue, arithmetic pipeline.
// Throughput: one item per cycle while out_stall is low; the divider is fully pipelined,
// one quotient bit per stage. Stages: input stage, queue, multiply, round add,
// ANGLE_BITS + 1 divide stages, output register.
// Reset: rst_n asynchronous, active low; clears all valid state and loads register defaults.
module hue_range_remap #(
    parameter int ANGLE_BITS = hrr_pkg::ANGLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hrr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [hrr_pkg::DATA_BITS-1:0] pwdata,
    output logic [hrr_pkg::DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [15:0]                   hue_in,
    input  logic [15:0]                   sat_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   hue_out,
    output logic [15:0]                   sat_out,
    output logic                          passed_through
);

    localparam int IW = hrr_pkg::item_bits(ANGLE_BITS);

    hrr_pkg::cfg_t cfg_reg;
    logic [2:0]    reg_idx;
    logic          wr_en;
    logic          q_full, q_empty, q_push, q_pop;
    logic [IW-1:0] q_wdata, q_rdata;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_start    <= 16'd0;
            cfg_reg.source_end      <= 16'hFFFF;
            cfg_reg.target_start    <= 16'd0;
            cfg_reg.target_end      <= 16'hFFFF;
            cfg_reg.mode_bits       <= 4'd0;
            cfg_reg.gray_limit      <= 16'd0;
            cfg_reg.gray_target_hue <= 16'd0;
            cfg_reg.gray_target_sat <= 16'd0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                hrr_pkg::REG_SRC_START: cfg_reg.source_start    <= pwdata[15:0];
                hrr_pkg::REG_SRC_END:   cfg_reg.source_end      <= pwdata[15:0];
                hrr_pkg::REG_TGT_START: cfg_reg.target_start    <= pwdata[15:0];
                hrr_pkg::REG_TGT_END:   cfg_reg.target_end      <= pwdata[15:0];
                hrr_pkg::REG_MODE:      cfg_reg.mode_bits       <= pwdata[3:0];
                hrr_pkg::REG_GRAY_LIM:  cfg_reg.gray_limit      <= pwdata[15:0];
                hrr_pkg::REG_GRAY_HUE:  cfg_reg.gray_target_hue <= pwdata[15:0];
                hrr_pkg::REG_GRAY_SAT:  cfg_reg.gray_target_sat <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            hrr_pkg::REG_SRC_START: prdata = {16'b0, cfg_reg.source_start};
            hrr_pkg::REG_SRC_END:   prdata = {16'b0, cfg_reg.source_end};
            hrr_pkg::REG_TGT_START: prdata = {16'b0, cfg_reg.target_start};
            hrr_pkg::REG_TGT_END:   prdata = {16'b0, cfg_reg.target_end};
            hrr_pkg::REG_MODE:      prdata = {28'b0, cfg_reg.mode_bits};
            hrr_pkg::REG_GRAY_LIM:  prdata = {16'b0, cfg_reg.gray_limit};
            hrr_pkg::REG_GRAY_HUE:  prdata = {16'b0, cfg_reg.gray_target_hue};
            hrr_pkg::REG_GRAY_SAT:  prdata = {16'b0, cfg_reg.gray_target_sat};
            default:                prdata = '0;
        endcase
    end

    hrr_front #(
        .W  (ANGLE_BITS),
        .IW (IW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .hue_in   (hue_in),
        .sat_in   (sat_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    hrr_queue #(
        .DW    (IW),
        .DEPTH (hrr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    hrr_back #(
        .W  (ANGLE_BITS),
        .IW (IW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hue_out        (hue_out),
        .sat_out        (sat_out),
        .passed_through (passed_through)
    );

endmodule
